// ===== hw/rtl/hmit_pkg.sv =====
// Shared constants, types and control structs for the hash match-or-insert table.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package hmit_pkg;

    localparam int BUCKETS  = 1024;
    localparam int SLOTS    = 8;

    localparam int KEY_W    = 24;
    localparam int IDX_W    = 14;
    localparam int NB_W     = 11;
    localparam int STATUS_W = 2;

    localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ROW_W    = SLOTS * KEY_W;
    localparam int IADDR_W  = BKT_W + SLOT_W;

    // hash = key*77 + 2222; the max key gives a value below 2**31
    localparam int HASH_MUL = 77;
    localparam int HASH_ADD = 2222;
    localparam int HASH_W   = KEY_W + 7;

    localparam logic [NB_W-1:0] NB_RESET = NB_W'(1024);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_MATCHED  = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic             accept;     // input beat taken, latch key and index
        logic             hash_load;  // load hash product, preset result to full
        logic             div_step;   // one remainder step
        logic             rd_row;     // read the bucket's key row
        logic             cmp;        // compare row, update key memory, read or write index memory
        logic             clr_wr;     // write a zero row during the clearing pass
        logic             load_out;   // move result into the output register
        logic [BKT_W-1:0] clr_addr;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic key_zero;
        logic out_busy;
    } t_sts;

endpackage

// ===== hw/rtl/hmit_if.sv =====
// Valid/ready channel interfaces for the input beat and the result beat.
// Depends on hmit_pkg for field widths.
interface hmit_in_if;
    logic                         valid;
    logic                         ready;
    logic [hmit_pkg::KEY_W-1:0]   key;
    logic [hmit_pkg::IDX_W-1:0]   item_index;

    modport source (output valid, output key, output item_index, input ready);
    modport sink   (input valid, input key, input item_index, output ready);
endinterface

interface hmit_out_if;
    logic                          valid;
    logic                          ready;
    logic [hmit_pkg::STATUS_W-1:0] status;
    logic [hmit_pkg::IDX_W-1:0]    match_index;

    modport source (output valid, output status, output match_index, input ready);
    modport sink   (input valid, input status, input match_index, output ready);
endinterface

// ===== hw/rtl/hash_match_or_insert_table.sv =====
// Hash match-or-insert table: one result beat for each input beat taken; a zero key
// skips the 31-step remainder loop. A new beat is taken only once the previous result
// is in the output register. The modulus is bucket-count wide; rows are read and
// written whole, one per cycle. Reset is synchronous, active low; afterwards a clearing
// pass zeroes the 1024 key rows with the input not ready. Configuration writes are
// taken throughout. Depends on hmit_pkg, hmit_if, hmit_ctrl and hmit_dp.
module hash_match_or_insert_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hmit_pkg::NB_W-1:0] i_cfg_wdata,
    hmit_in_if.sink                   i_in,
    hmit_out_if.source                o_out
);

    // Flow of one beat:
    //   idle    - ready high, beat latched
    //   hash    - key*77+2222 registered (zero key goes straight to the result as full)
    //   div     - one remainder bit per cycle against the effective bucket count
    //   read    - the bucket's row of SLOTS keys read from the key memory
    //   cmp     - all slots compared at once; the row is written back with the slot
    //             emptied (match) or filled (insert), the index memory read or written
    //   done    - result moved into the output register once it is free
    // The output register lets the next beat be taken while a result waits.

    hmit_pkg::t_cmd cmd;
    hmit_pkg::t_sts sts;

    hmit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hmit_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_key         (i_in.key),
        .i_item_index  (i_in.item_index),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_match_index (o_out.match_index),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

// ===== hw/rtl/hmit_ctrl.sv =====
// Sequencer for the hash table: clearing pass, hash, remainder loop, row access, result.
// Depends on hmit_pkg (t_cmd, t_sts, sizes).
module hmit_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hmit_pkg::t_sts i_sts,
    output hmit_pkg::t_cmd o_cmd
);

    localparam int CNT_W = (hmit_pkg::BKT_W > $clog2(hmit_pkg::HASH_W)) ?
                           hmit_pkg::BKT_W : $clog2(hmit_pkg::HASH_W);
    localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(hmit_pkg::BUCKETS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(hmit_pkg::HASH_W - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_DIV,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.clr_addr = r_cnt[hmit_pkg::BKT_W-1:0];
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (r_cnt == CLR_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_load = 1'b1;
                n_cnt           = '0;
                n_state         = i_sts.key_zero ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_READ;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTH
    // the clearing pass must finish before any beat is taken
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_cmd.accept)
        else $error("input taken during clearing pass");

    // the row read follows a remainder step, with the step counter back at zero; the loop runs HASH_W steps
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_row |-> $past(o_cmd.div_step) && (r_cnt == '0))
        else $error("row read without finished remainder loop");

    // a result is loaded only with the output side able to take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_sts.out_busy)
        else $error("result loaded over a pending beat");
`endif

endmodule

// ===== hw/rtl/hmit_dp.sv =====
// Datapath: bucket count register, hash and remainder unit, key row and index memories,
// slot compare and output register. Depends on hmit_pkg; driven by hmit_ctrl.
module hmit_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hmit_pkg::NB_W-1:0]     i_cfg_wdata,
    input  logic [hmit_pkg::KEY_W-1:0]    i_key,
    input  logic [hmit_pkg::IDX_W-1:0]    i_item_index,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [hmit_pkg::STATUS_W-1:0] o_status,
    output logic [hmit_pkg::IDX_W-1:0]    o_match_index,
    input  hmit_pkg::t_cmd                i_cmd,
    output hmit_pkg::t_sts                o_sts
);

    localparam int KEY_W  = hmit_pkg::KEY_W;
    localparam int SLOT_W = hmit_pkg::SLOT_W;
    localparam int NB_W   = hmit_pkg::NB_W;

    logic [hmit_pkg::NB_W-1:0]     r_num_buckets;
    logic [KEY_W-1:0]              r_key;
    logic [hmit_pkg::IDX_W-1:0]    r_item;
    logic [hmit_pkg::HASH_W-1:0]   r_div;
    logic [NB_W-1:0]               r_rem;
    logic [hmit_pkg::ROW_W-1:0]    r_row;
    logic [hmit_pkg::IDX_W-1:0]    r_idx_rd;
    hmit_pkg::t_status             r_res_status;
    logic                          r_out_valid;
    hmit_pkg::t_status             r_out_status;
    logic [hmit_pkg::IDX_W-1:0]    r_out_idx;

    logic [hmit_pkg::ROW_W-1:0]    key_mem [hmit_pkg::BUCKETS];
    logic [hmit_pkg::IDX_W-1:0]    idx_mem [hmit_pkg::BUCKETS * hmit_pkg::SLOTS];

    logic [NB_W-1:0]               eff_b;
    logic [NB_W:0]                 trial;
    logic [hmit_pkg::BKT_W-1:0]    bucket;
    logic                          hit, free;
    logic [SLOT_W-1:0]             hit_slot, free_slot;
    logic [hmit_pkg::ROW_W-1:0]    n_row;
    logic                          row_we;
    logic [hmit_pkg::BKT_W-1:0]    row_wa;
    logic [hmit_pkg::ROW_W-1:0]    row_wd;
    logic [hmit_pkg::IADDR_W-1:0]  idx_addr;

    // effective modulus: zero means one bucket, above BUCKETS saturates
    always_comb begin
        eff_b = r_num_buckets;
        if (r_num_buckets == '0) begin
            eff_b = NB_W'(1);
        end else if (32'(r_num_buckets) > 32'(hmit_pkg::BUCKETS)) begin
            eff_b = NB_W'(hmit_pkg::BUCKETS);
        end
    end

    assign trial  = {r_rem, r_div[hmit_pkg::HASH_W-1]};
    assign bucket = hmit_pkg::BKT_W'(r_rem);

    // lowest matching slot, lowest empty slot
    always_comb begin
        hit       = 1'b0;
        free      = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        for (int s = hmit_pkg::SLOTS - 1; s >= 0; s--) begin
            if (r_row[s*KEY_W +: KEY_W] == r_key) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(s);
            end
            if (r_row[s*KEY_W +: KEY_W] == '0) begin
                free      = 1'b1;
                free_slot = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        n_row = r_row;
        if (hit) begin
            n_row[hit_slot*KEY_W +: KEY_W] = '0;
        end else begin
            n_row[free_slot*KEY_W +: KEY_W] = r_key;
        end
    end

    assign row_we   = i_cmd.clr_wr | (i_cmd.cmp & (hit | free));
    assign row_wa   = i_cmd.clr_wr ? i_cmd.clr_addr : bucket;
    assign row_wd   = i_cmd.clr_wr ? '0 : n_row;
    assign idx_addr = {bucket, (hit ? hit_slot : free_slot)};

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            key_mem[row_wa] <= row_wd;
        end
        if (i_cmd.rd_row) begin
            r_row <= key_mem[bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp && !hit && free) begin
            idx_mem[idx_addr] <= r_item;
        end
        if (i_cmd.cmp && hit) begin
            r_idx_rd <= idx_mem[idx_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key  <= i_key;
            r_item <= i_item_index;
        end
        if (i_cmd.hash_load) begin
            r_div        <= hmit_pkg::HASH_W'(32'(r_key) * hmit_pkg::HASH_MUL
                                              + hmit_pkg::HASH_ADD);
            r_rem        <= '0;
            r_res_status <= hmit_pkg::ST_FULL;
        end
        if (i_cmd.div_step) begin
            r_div <= r_div << 1;
            if (trial >= {1'b0, eff_b}) begin
                r_rem <= NB_W'(trial - {1'b0, eff_b});
            end else begin
                r_rem <= NB_W'(trial);
            end
        end
        if (i_cmd.cmp) begin
            if (hit) begin
                r_res_status <= hmit_pkg::ST_MATCHED;
            end else if (free) begin
                r_res_status <= hmit_pkg::ST_INSERTED;
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_idx    <= (r_res_status == hmit_pkg::ST_MATCHED) ? r_idx_rd : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buckets <= hmit_pkg::NB_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_buckets <= i_cfg_wdata;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.key_zero = (r_key == '0);
    assign o_sts.out_busy = r_out_valid & ~i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_match_index = r_out_idx;

`ifndef SYNTH
    // remainder stays below the modulus through the whole loop
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_rem < eff_b))
        else $error("remainder out of range");

    // a non-match result carries a zero index
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != hmit_pkg::ST_MATCHED)) |-> (r_out_idx == '0))
        else $error("index on a non-match result");

    // a memory update never happens while the clearing pass writes
    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !(i_cmd.cmp || i_cmd.accept || i_cmd.load_out))
        else $error("activity during clearing pass");
`endif

endmodule
